// File: hdl/kms_pkg.sv
package kms_pkg;

    localparam int ROW_COUNT_DEFAULT = 8;

    localparam logic [15:0] SETTLE_RESET   = 16'd1;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd10;
    localparam logic [23:0] PIN_MAP_RESET  = 24'd16434824;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_SETTLE   = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [1:0] REG_PIN_MAP  = 2'd2;

    typedef enum logic [1:0] {
        PH_SCAN1    = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_SCAN2    = 2'd2
    } phase_t;

    // wiring index to key number, entry i at bits 3i+2:3i
    function automatic logic [2:0] map_entry(input logic [23:0] pin_map, input logic [2:0] idx);
        logic [4:0] sh;
        sh = {1'b0, idx, 1'b0} + {2'b00, idx};
        return 3'(pin_map >> sh);
    endfunction

endpackage

// File: hdl/kms_if.sv
interface kms_sample_if;
    logic       valid;
    logic       ready;
    logic [7:0] col_lines;

    modport source (output valid, output col_lines, input ready);
    modport sink (input valid, input col_lines, output ready);
endinterface

interface kms_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] row_drive;
    logic       event_valid;
    logic       event_kind;
    logic [2:0] key_row;
    logic [2:0] key_col;

    modport source (output valid, output row_drive, output event_valid, output event_kind,
                    output key_row, output key_col, input ready);
    modport sink (input valid, input row_drive, input event_valid, input event_kind,
                  input key_row, input key_col, output ready);
endinterface

// File: hdl/keypad_matrix_scan_debounce_core.sv
// Keypad matrix scanner with debounce. Every sample transaction is one scan tick
// carrying the active-low column lines; each produces exactly one result transaction
// with the active-low row drive for that tick and an optional press/release event.
// One transaction per clock is sustained while the result side accepts: a transaction
// is registered, evaluated by the combinational scan/debounce logic and lands in the
// result register, which stalls only while its ready is low.
// Registers (APB, byte address 4*i): 0 settle_ticks, 1 debounce_ticks, 2 pin_map.
// Write them only when no transaction is in flight.
module keypad_matrix_scan_debounce_core #(
    parameter int ROW_COUNT = kms_pkg::ROW_COUNT_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    kms_sample_if.sink         sample,
    kms_result_if.source       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // configuration
    logic [15:0] settle_reg;
    logic [15:0] debounce_reg;
    logic [23:0] pin_map_reg;
    logic        cfg_wr;

    // pipeline
    logic        s1_valid_reg;
    logic [7:0]  cols_reg;
    logic        res_valid_reg;
    logic [7:0]  drive_reg;
    logic        ev_valid_reg;
    logic        ev_kind_reg;
    logic [2:0]  ev_row_reg;
    logic [2:0]  ev_col_reg;
    logic        advance;
    logic        take;

    // scanner state
    kms_pkg::phase_t phase_reg, phase_next;
    logic        key_held_reg, key_held_next;
    logic [2:0]  held_row_reg, held_row_next;
    logic [2:0]  held_col_reg, held_col_next;
    logic [2:0]  cand_row_reg, cand_row_next;
    logic [2:0]  cand_col_reg, cand_col_next;
    logic [2:0]  scan_row_reg, scan_row_next;
    logic [15:0] wait_reg, wait_next;

    // decode
    logic [7:0]  active;
    logic [2:0]  col_idx;
    logic [15:0] need;
    logic [15:0] cnt_inc;
    logic        sampled;
    logic        last_row;
    logic [2:0]  hit_row;
    logic [2:0]  hit_col;
    logic        scan_hit;
    logic        scan_miss;
    logic        scan_next_row;
    logic        is_deb;
    logic        is_scan2;
    logic        same_held;
    logic        rel_evt;
    logic        press_evt;

    // outputs of the evaluation
    logic [7:0]  drive_c;
    logic        ev_valid_c;
    logic        ev_kind_c;
    logic [2:0]  ev_row_c;
    logic [2:0]  ev_col_c;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            kms_pkg::REG_SETTLE:   prdata = {16'd0, settle_reg};
            kms_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_reg};
            kms_pkg::REG_PIN_MAP:  prdata = {8'd0, pin_map_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg   <= kms_pkg::SETTLE_RESET;
            debounce_reg <= kms_pkg::DEBOUNCE_RESET;
            pin_map_reg  <= kms_pkg::PIN_MAP_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                kms_pkg::REG_SETTLE:   settle_reg   <= pwdata[15:0];
                kms_pkg::REG_DEBOUNCE: debounce_reg <= pwdata[15:0];
                kms_pkg::REG_PIN_MAP:  pin_map_reg  <= pwdata[23:0];
                default:               ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign advance      = !res_valid_reg || result.ready;
    assign sample.ready = !s1_valid_reg || advance;
    assign take         = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            cols_reg <= sample.col_lines;
        end
        if (take)
        begin
            drive_reg    <= drive_c;
            ev_valid_reg <= ev_valid_c;
            ev_kind_reg  <= ev_kind_c;
            ev_row_reg   <= ev_row_c;
            ev_col_reg   <= ev_col_c;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.row_drive   = drive_reg;
    assign result.event_valid = ev_valid_reg;
    assign result.event_kind  = ev_kind_reg;
    assign result.key_row     = ev_row_reg;
    assign result.key_col     = ev_col_reg;

    // ---------------- scan decode ----------------
    always_comb
    begin
        active  = ~cols_reg;
        col_idx = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (active[i])
            begin
                col_idx = 3'(i);
            end
        end
        need     = (settle_reg == 16'd0) ? 16'd1 : settle_reg;
        cnt_inc  = (wait_reg == 16'hFFFF) ? wait_reg : wait_reg + 16'd1;
        sampled  = cnt_inc >= need;
        last_row = !(({1'b0, scan_row_reg} + 4'd1) < 4'(ROW_COUNT));
        hit_row  = kms_pkg::map_entry(pin_map_reg, scan_row_reg);
        hit_col  = kms_pkg::map_entry(pin_map_reg, col_idx);

        scan_hit      = sampled && (|active);
        scan_miss     = sampled && !(|active) && last_row;
        scan_next_row = sampled && !(|active) && !last_row;

        is_deb    = phase_reg == kms_pkg::PH_DEBOUNCE;
        is_scan2  = phase_reg == kms_pkg::PH_SCAN2;
        same_held = (hit_row == held_row_reg) && (hit_col == held_col_reg);

        // a different key on the first scan releases at once; the confirming scan
        // releases on an empty or different result
        rel_evt = !is_deb && key_held_reg &&
                  ((!is_scan2 && scan_hit && !same_held) ||
                   (is_scan2 && (scan_miss || (scan_hit && !same_held))));
        press_evt = !is_deb && is_scan2 && !key_held_reg && scan_hit &&
                    (hit_row == cand_row_reg) && (hit_col == cand_col_reg);
    end

    // ---------------- next state ----------------
    always_comb
    begin
        phase_next    = phase_reg;
        key_held_next = key_held_reg;
        held_row_next = held_row_reg;
        held_col_next = held_col_reg;
        cand_row_next = cand_row_reg;
        cand_col_next = cand_col_reg;
        scan_row_next = scan_row_reg;
        wait_next     = wait_reg;

        if (is_deb)
        begin
            wait_next = cnt_inc;
            if (cnt_inc >= debounce_reg)
            begin
                phase_next    = kms_pkg::PH_SCAN2;
                scan_row_next = 3'd0;
                wait_next     = 16'd0;
            end
        end
        else
        begin
            // unused phase code starts a first scan
            phase_next = is_scan2 ? kms_pkg::PH_SCAN2 : kms_pkg::PH_SCAN1;
            wait_next  = cnt_inc;
            if (scan_next_row)
            begin
                scan_row_next = scan_row_reg + 3'd1;
                wait_next     = 16'd0;
            end
            if (scan_hit || scan_miss)
            begin
                scan_row_next = 3'd0;
                wait_next     = 16'd0;
                phase_next    = kms_pkg::PH_SCAN1;
                if (!is_scan2)
                begin
                    if ((key_held_reg && scan_miss) || (!key_held_reg && scan_hit))
                    begin
                        phase_next = (debounce_reg == 16'd0) ? kms_pkg::PH_SCAN2
                                                             : kms_pkg::PH_DEBOUNCE;
                    end
                    if (!key_held_reg && scan_hit)
                    begin
                        cand_row_next = hit_row;
                        cand_col_next = hit_col;
                    end
                end
            end
        end

        if (rel_evt)
        begin
            key_held_next = 1'b0;
        end
        if (press_evt)
        begin
            key_held_next = 1'b1;
            held_row_next = hit_row;
            held_col_next = hit_col;
        end
    end

    // ---------------- outputs ----------------
    always_comb
    begin
        drive_c    = is_deb ? 8'hFF : ~(8'd1 << scan_row_reg);
        ev_valid_c = rel_evt || press_evt;
        ev_kind_c  = rel_evt;
        ev_row_c   = 3'd0;
        ev_col_c   = 3'd0;
        if (rel_evt)
        begin
            ev_row_c = held_row_reg;
            ev_col_c = held_col_reg;
        end
        else if (press_evt)
        begin
            ev_row_c = hit_row;
            ev_col_c = hit_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= kms_pkg::PH_SCAN1;
            key_held_reg <= 1'b0;
            held_row_reg <= 3'd0;
            held_col_reg <= 3'd0;
            cand_row_reg <= 3'd0;
            cand_col_reg <= 3'd0;
            scan_row_reg <= 3'd0;
            wait_reg     <= 16'd0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            key_held_reg <= key_held_next;
            held_row_reg <= held_row_next;
            held_col_reg <= held_col_next;
            cand_row_reg <= cand_row_next;
            cand_col_reg <= cand_col_next;
            scan_row_reg <= scan_row_next;
            wait_reg     <= wait_next;
        end
    end

    // ---------------- assertions ----------------
    // events only come out of scan ticks, where exactly one row is driven
    a_event_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.event_valid) |-> ($countones(~result.row_drive) == 1))
        else $error("event reported on a tick that drives no single row");

    // quiet ticks carry zero event fields
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.event_valid) |->
            (!result.event_kind && result.key_row == 3'd0 && result.key_col == 3'd0))
        else $error("event fields nonzero without an event");

    // a committed press leaves the key held
    a_press_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (take && press_evt) |=> key_held_reg)
        else $error("press did not mark the key held");

endmodule
